### sv/sfd_pkg.sv
// Shared types and constants for the SBUS frame decoder.
// No dependencies; imported by every module of the decoder.
`default_nettype none

package sfd_pkg;

  localparam int RING_LEN    = 25;
  localparam int NUM_CH      = 16;
  localparam int RAW_W       = 11;
  localparam int CH_W        = 4;
  localparam int PCT_W       = 8;
  localparam int FRAME_BYTES = 22;
  localparam int FRAME_W     = FRAME_BYTES * 8;

  localparam logic [7:0]       HEAD_BYTE = 8'h0F;
  localparam logic [7:0]       TAIL_BYTE = 8'h00;
  localparam logic [CH_W-1:0]  LAST_CH   = CH_W'(NUM_CH - 1);
  localparam logic [11:0]      PCT_LOW   = 12'd300;
  // (raw-300)*100/1400 == (raw-300)/14; 4682/2^16 is exact for magnitudes below 5461
  localparam logic [12:0]      RECIP_14  = 13'd4682;

  typedef logic [7:0]         byte_t;
  typedef logic [FRAME_W-1:0] frame_t;

  typedef struct packed {
    logic   valid;
    frame_t data;
  } push_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

`default_nettype wire

### sv/sfd_front.sv
// Front end: 25-byte shift line holding the last bytes received, frame detect.
// Depends on sfd_pkg; pushes detected frame payloads into sfd_queue.
`default_nettype none

module sfd_front (
  input  wire             clk,
  input  wire             rst,
  input  wire             s_tvalid,
  output logic            s_tready,
  input  wire [7:0]       s_tdata,
  input  wire             q_full,
  output sfd_pkg::push_t  push
);
  import sfd_pkg::*;

  // ring[0] is the oldest byte, ring[RING_LEN-1] the newest
  byte_t ring [RING_LEN];
  logic  accept;

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < RING_LEN; i++) ring[i] <= '0;
    end else if (accept) begin
      for (int i = 0; i < RING_LEN - 1; i++) ring[i] <= ring[i+1];
      ring[RING_LEN-1] <= s_tdata;
    end
  end

  // after the shift the oldest byte is today's ring[1]; payload is frame bytes 1..22
  always_comb begin
    push.valid = accept && (s_tdata == TAIL_BYTE) && (ring[1] == HEAD_BYTE);
    for (int j = 0; j < FRAME_BYTES; j++) push.data[8*j +: 8] = ring[j+2];
  end

endmodule

`default_nettype wire

### sv/sfd_queue.sv
// Two-entry frame queue between the front and back ends.
// Depends on sfd_pkg.
`default_nettype none

module sfd_queue (
  input  wire              clk,
  input  wire              rst,
  input  sfd_pkg::push_t   push,
  input  wire              pop,
  output sfd_pkg::frame_t  head,
  output sfd_pkg::q_stat_t q_stat
);
  import sfd_pkg::*;

  frame_t     entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign do_push = push.valid && (count != 2'd2);
  assign do_pop  = pop && (count != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop)  rd_ptr <= !rd_ptr;
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) entry[wr_ptr] <= push.data;
  end

  assign head         = entry[rd_ptr];
  assign q_stat.full  = (count == 2'd2);
  assign q_stat.empty = (count == 2'd0);

endmodule

`default_nettype wire

### sv/sfd_back.sv
// Back end: walks the 16 channels of the head frame, unpacks and scales each.
// Depends on sfd_pkg; reads sfd_queue, drives the result stream.
`default_nettype none

module sfd_back (
  input  wire              clk,
  input  wire              rst,
  input  sfd_pkg::frame_t  head,
  input  wire              q_empty,
  output logic             pop,
  output logic             m_tvalid,
  input  wire              m_tready,
  output logic [23:0]      m_tdata,
  output logic             m_tlast
);
  import sfd_pkg::*;

  logic              en;
  logic              take;
  logic [CH_W-1:0]   ch_cnt;
  logic [7:0]        bit_idx;
  logic [RAW_W-1:0]  raw_sel;
  logic [11:0]       diff;
  logic [RAW_W-1:0]  mag;

  // stage A: unpacked value and magnitude of raw-300
  logic              a_valid;
  logic [CH_W-1:0]   a_ch;
  logic [RAW_W-1:0]  a_raw;
  logic              a_neg;
  logic [RAW_W-1:0]  a_mag;

  logic [23:0]       prod;
  logic [6:0]        quo;
  logic [PCT_W-1:0]  pct;

  assign en   = !m_tvalid || m_tready;
  assign take = en && !q_empty;
  assign pop  = take && (ch_cnt == LAST_CH);

  assign bit_idx = 8'(ch_cnt) * 8'd11;
  assign raw_sel = head[bit_idx +: RAW_W];
  assign diff    = {1'b0, raw_sel} - PCT_LOW;
  assign mag     = diff[11] ? RAW_W'(-diff) : diff[RAW_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      ch_cnt   <= '0;
      a_valid  <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (en) begin
      if (take) ch_cnt <= ch_cnt + 1'b1;
      a_valid  <= !q_empty;
      m_tvalid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      a_ch  <= ch_cnt;
      a_raw <= raw_sel;
      a_neg <= diff[11];
      a_mag <= mag;
    end
  end

  assign prod = 24'(a_mag * RECIP_14);
  assign quo  = prod[22:16];
  assign pct  = a_neg ? PCT_W'(-{1'b0, quo}) : {1'b0, quo};

  always_ff @(posedge clk) begin
    if (en && a_valid) begin
      m_tdata <= {1'b0, pct, a_raw, a_ch};
      m_tlast <= (a_ch == LAST_CH);
    end
  end

endmodule

`default_nettype wire

### sv/sbus_frame_decoder.sv
// Channel   Dir  Handshake           Payload
// s_*       in   s_tvalid/s_tready   s_tdata[7:0] = rx_byte
// m_*       out  m_tvalid/m_tready   m_tdata: channel, raw_value, percent; m_tlast
//
// One byte per cycle is taken while the two-entry frame queue has room.
// Each detected frame is emitted as 16 results, one per cycle while m_tready does not stall,
// set by the back-end channel counter; the first result passes the queue entry, stage A and
// the output register. Reset clears the 25-byte ring, the queue and the pipeline.
// A stalled result stream fills the queue and then holds s_tready low.
// Top level: sfd_front, sfd_queue, sfd_back; depends on sfd_pkg.
`default_nettype none

module sbus_frame_decoder (
  input  wire        clk,
  input  wire        rst,
  input  wire        s_tvalid,
  output logic       s_tready,
  input  wire [7:0]  s_tdata,   // [7:0] rx_byte
  output logic       m_tvalid,
  input  wire        m_tready,
  output logic [23:0] m_tdata,  // [3:0] channel, [14:4] raw_value, [22:15] percent, [23] 0
  output logic       m_tlast    // last_channel
);
  import sfd_pkg::*;

  push_t   push;
  q_stat_t q_stat;
  frame_t  head;
  logic    pop;

  sfd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .q_full   (q_stat.full),
    .push     (push)
  );

  sfd_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .pop    (pop),
    .head   (head),
    .q_stat (q_stat)
  );

  sfd_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .q_empty  (q_stat.empty),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

`default_nettype wire

### sv/sfd_checker.sv
// Port-level checks for sbus_frame_decoder, attached by bind.
// Depends only on the top-level ports.
`default_nettype none

module sfd_checker (
  input wire        clk,
  input wire        rst,
  input wire        s_tvalid,
  input wire        s_tready,
  input wire [7:0]  s_tdata,
  input wire        m_tvalid,
  input wire        m_tready,
  input wire [23:0] m_tdata,
  input wire        m_tlast
);

  logic [3:0] exp_ch;

  always_ff @(posedge clk) begin
    if (rst) exp_ch <= '0;
    else if (m_tvalid && m_tready) exp_ch <= m_tdata[3:0] + 4'd1;
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result changed while stalled");

  // channels run 0..15 in order, last flag only on channel 15
  a_order: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[3:0] == exp_ch) && (m_tlast == (m_tdata[3:0] == 4'd15)))
    else $error("channel out of sequence or last flag wrong");

  a_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> $signed(m_tdata[22:15]) >= -8'sd21 && $signed(m_tdata[22:15]) <= 8'sd124
                 && !m_tdata[23])
    else $error("percent out of range");

  a_in_known: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |-> !$isunknown(s_tdata))
    else $error("unknown byte in accepted request");

  a_rst: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

endmodule

bind sbus_frame_decoder sfd_checker u_sfd_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

`default_nettype wire

### tb/sbus_frame_checker.sv
// Scoreboard for sbus_frame_decoder: mirrors the 25-byte receive ring, decodes
// each detected frame into 16 channel results and checks the result stream.
// Depends on sfd_pkg for widths and the frame marker bytes.
module sbus_frame_checker
  import sfd_pkg::*;
(
  input  wire        clk,
  input  wire        rst,
  input  wire        s_tvalid,
  input  wire        s_tready,
  input  wire [7:0]  s_tdata,   // [7:0] rx_byte
  input  wire        m_tvalid,
  input  wire        m_tready,
  input  wire [23:0] m_tdata,   // [3:0] channel, [14:4] raw_value, [22:15] percent, [23] 0
  input  wire        m_tlast,   // last_channel
  output int         mismatches,
  output int         outstanding,
  output int         frames_seen,
  output int         results_checked
);

  localparam int PCT_FLOOR = 300;
  localparam int PCT_SPAN  = 1400;
  localparam int PCT_SCALE = 100;
  localparam int MAX_SHOWN = 10;

  typedef struct packed {
    logic [CH_W-1:0]  channel;
    logic [RAW_W-1:0] raw_value;
    logic [PCT_W-1:0] percent;
    logic             last_channel;
  } chan_result_t;

  byte_t        rx_ring [RING_LEN];
  int unsigned  wr_slot;
  chan_result_t channel_q [$];
  int           err_cnt   = 0;
  int           frame_cnt = 0;
  int           check_cnt = 0;

  task automatic flag_error(input string what);
    err_cnt++;
    if (err_cnt <= MAX_SHOWN) $display("[%0t] decode error: %s", $time, what);
  endtask

  always @(posedge clk) begin : scoreboard
    int unsigned  head_slot;
    frame_t       payload;
    chan_result_t want;
    chan_result_t got;
    int           scaled;
    if (rst) begin
      foreach (rx_ring[i]) rx_ring[i] = '0;
      wr_slot = 0;
      channel_q.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got.channel      = m_tdata[CH_W-1:0];
        got.raw_value    = m_tdata[CH_W +: RAW_W];
        got.percent      = m_tdata[CH_W+RAW_W +: PCT_W];
        got.last_channel = m_tlast;
        if (channel_q.size() == 0) begin
          flag_error($sformatf("result ch %0d raw %0d with no frame pending",
                               got.channel, got.raw_value));
        end else begin
          want = channel_q.pop_front();
          check_cnt++;
          if (got !== want)
            flag_error($sformatf({"expected ch %0d raw %0d pct %0d last %0b, ",
                                  "got ch %0d raw %0d pct %0d last %0b"},
                                 want.channel, want.raw_value, $signed(want.percent),
                                 want.last_channel, got.channel, got.raw_value,
                                 $signed(got.percent), got.last_channel));
        end
      end
      if (s_tvalid && s_tready) begin
        rx_ring[wr_slot] = s_tdata;
        // the slot after the newest byte holds the oldest one
        head_slot = (wr_slot + 1) % RING_LEN;
        if (s_tdata == TAIL_BYTE && rx_ring[head_slot] == HEAD_BYTE) begin
          for (int k = 0; k < FRAME_BYTES; k++)
            payload[k*8 +: 8] = rx_ring[(head_slot + 1 + k) % RING_LEN];
          for (int c = 0; c < NUM_CH; c++) begin
            want.channel      = CH_W'(c);
            want.raw_value    = payload[c*RAW_W +: RAW_W];
            scaled            = (int'(want.raw_value) - PCT_FLOOR) * PCT_SCALE / PCT_SPAN;
            want.percent      = scaled[PCT_W-1:0];
            want.last_channel = (want.channel == LAST_CH);
            channel_q.push_back(want);
          end
          frame_cnt++;
        end
        wr_slot = head_slot;
      end
    end
    mismatches      <= err_cnt;
    outstanding     <= channel_q.size();
    frames_seen     <= frame_cnt;
    results_checked <= check_cnt;
  end

endmodule

### tb/tb_top.sv
// Top of the sbus_frame_decoder testbench: clock, reset, byte stream stimulus,
// result-side backpressure, stall watchdog and the final verdict.
// Depends on sfd_pkg, sbus_frame_decoder and sbus_frame_checker.
module tb_top;
  import sfd_pkg::*;

  localparam int ITEM_TARGET  = 420;
  localparam int CALM_FROM    = 330;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 40;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  byte_t       s_tdata  = '0;
  logic        m_tready = 1'b0;
  wire         s_tready;
  wire         m_tvalid;
  wire [23:0]  m_tdata;
  wire         m_tlast;

  int mismatches;
  int outstanding;
  int frames_seen;
  int results_checked;
  int bytes_sent  = 0;
  int idle_cycles = 0;
  bit calm        = 1'b0;

  byte_t            frame_buf  [RING_LEN];
  logic [RAW_W-1:0] chan_vals  [NUM_CH];
  // values around the percent breakpoints and the ends of the 11-bit range
  logic [RAW_W-1:0] corner_raw [NUM_CH] = '{
    11'd0, 11'd1, 11'd285, 11'd286, 11'd299, 11'd300, 11'd301, 11'd313,
    11'd314, 11'd1024, 11'd1365, 11'd1700, 11'd1713, 11'd1714, 11'd2046, 11'd2047
  };

  sbus_frame_decoder u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  sbus_frame_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .m_tlast         (m_tlast),
    .mismatches      (mismatches),
    .outstanding     (outstanding),
    .frames_seen     (frames_seen),
    .results_checked (results_checked)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog: any accepted request on either side restarts the count
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result side: ready bursts broken by stalls, always ready once calm
  initial begin
    @(negedge rst);
    forever begin
      m_tready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk);
      if (!calm) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
    end
  end

  task automatic send_byte(input byte_t b);
    if (!calm && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    bytes_sent++;
    if (bytes_sent >= CALM_FROM) calm = 1'b1;
  endtask

  // lay the 16 channel values LSB first across bytes 1..22 between the markers
  task automatic pack_frame();
    frame_t bits;
    for (int c = 0; c < NUM_CH; c++) bits[c*RAW_W +: RAW_W] = chan_vals[c];
    frame_buf[0] = HEAD_BYTE;
    for (int k = 0; k < FRAME_BYTES; k++) frame_buf[k+1] = bits[k*8 +: 8];
    frame_buf[FRAME_BYTES+1] = byte_t'($urandom);
    frame_buf[RING_LEN-1]    = TAIL_BYTE;
  endtask

  task automatic send_frame(input int unsigned nbytes);
    for (int k = 0; k < nbytes; k++) send_byte(frame_buf[k]);
  endtask

  initial begin
    int unsigned pick;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // a tail byte straight after reset must not match the cleared ring
    send_byte(TAIL_BYTE);
    foreach (chan_vals[c]) chan_vals[c] = corner_raw[c];
    pack_frame();
    send_frame(RING_LEN);

    while (bytes_sent < ITEM_TARGET) begin
      pick = $urandom_range(0, 9);
      if (pick <= 6) begin
        foreach (chan_vals[c])
          chan_vals[c] = ($urandom_range(0, 3) == 0) ? corner_raw[$urandom_range(0, NUM_CH-1)]
                                                      : RAW_W'($urandom_range(0, 2047));
        pack_frame();
        if ($urandom_range(0, 2) == 0) begin
          // second byte is a head marker, so one more tail closes an overlapping frame
          frame_buf[1] = HEAD_BYTE;
          send_frame(RING_LEN);
          send_byte(TAIL_BYTE);
        end else begin
          send_frame(RING_LEN);
        end
      end else if (pick == 7) begin
        repeat ($urandom_range(1, 12)) begin
          case ($urandom_range(0, 5))
            0:       send_byte(HEAD_BYTE);
            1:       send_byte(TAIL_BYTE);
            default: send_byte(byte_t'($urandom));
          endcase
        end
      end else if (pick == 8) begin
        // truncated frame
        foreach (chan_vals[c]) chan_vals[c] = RAW_W'($urandom);
        pack_frame();
        send_frame($urandom_range(2, RING_LEN - 2));
      end else begin
        // one byte short: tail lands a slot early
        foreach (chan_vals[c]) chan_vals[c] = RAW_W'($urandom);
        pack_frame();
        frame_buf[RING_LEN-2] = TAIL_BYTE;
        send_frame(RING_LEN - 1);
      end
    end
    s_tvalid <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Streamed %0d bytes with frames, noise and broken sequences;", bytes_sent);
    $display("%0d frames decoded, %0d channel results checked", frames_seen,
             results_checked);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
